// ===== src/pip_pkg.sv =====
// Shared types, widths and codes for the point-in-polygon test unit.
package pip_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
   localparam logic [1:0] LOC_BOUNDARY = 2'd1;
   localparam logic [1:0] LOC_INSIDE   = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef struct packed {
      logic     fixed;
      logic     fixed_zero;
      diff_type d1;
      diff_type d2;
      diff_type d3;
      diff_type d4;
   } edge_type;

   typedef struct packed {
      logic     first;
      logic     last;
      edge_type edge_a;
      edge_type edge_b;
   } job_type;

   typedef struct packed {
      logic     fixed;
      logic     fixed_zero;
      prod_type p;
      prod_type q;
   } prod_pair_type;

   typedef struct packed {
      logic zero;
      logic neg;
   } sign_type;

   localparam sign_type SIGN_MINUS_ONE = '{zero: 1'b0, neg: 1'b1};
   localparam sign_type SIGN_PLUS_ONE  = '{zero: 1'b0, neg: 1'b0};
   localparam sign_type SIGN_ZERO      = '{zero: 1'b1, neg: 1'b0};

endpackage

// ===== src/point_in_polygon_test_unit.sv =====
// Top level of the point-in-polygon test unit: front end, queue and back end.
// One vertex request is taken per cycle while the queue is not full; the queue holds four prepared requests.
// A last vertex's location passes through the queue slot, the registered cross-product stage
// and the response register, and stalls can hold it back on the way.
// Reset empties the queue and pipeline, clears the held coordinates to zero and
// sets the running sign to minus one; no clearing pass is needed.
module point_in_polygon_test_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pip_pkg::coord_type req_point_x,
   input  pip_pkg::coord_type req_point_y,
   input  pip_pkg::coord_type req_vertex_x,
   input  pip_pkg::coord_type req_vertex_y,
   input  logic               req_first_vertex,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_location
);

   logic             push, pop, queue_full, queue_not_empty;
   pip_pkg::job_type push_job, head_job;

   pip_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .queue_full       (queue_full),
      .push             (push),
      .job              (push_job)
   );

   pip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .head_job  (head_job)
   );

   pip_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (queue_not_empty),
      .job          (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_location (rsp_location)
   );

endmodule

// ===== src/pip_front.sv =====
// Front end: accepts vertices, holds the query state and prepares the edge tests.
module pip_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pip_pkg::coord_type    req_point_x,
   input  pip_pkg::coord_type    req_point_y,
   input  pip_pkg::coord_type    req_vertex_x,
   input  pip_pkg::coord_type    req_vertex_y,
   input  logic                  req_first_vertex,
   input  logic                  req_last_vertex,
   input  logic                  queue_full,
   output logic                  push,
   output pip_pkg::job_type      job
);

   pip_pkg::coord_type held_x_ff, held_x_in;
   pip_pkg::coord_type held_y_ff, held_y_in;
   pip_pkg::coord_type start_x_ff, start_x_in;
   pip_pkg::coord_type start_y_ff, start_y_in;
   pip_pkg::coord_type prev_x_ff, prev_x_in;
   pip_pkg::coord_type prev_y_ff, prev_y_in;
   pip_pkg::coord_type ax, ay, sx, sy;
   logic               accept;

   function automatic pip_pkg::edge_type edge_prep(
      input pip_pkg::coord_type px, input pip_pkg::coord_type py,
      input pip_pkg::coord_type bx, input pip_pkg::coord_type by,
      input pip_pkg::coord_type cx, input pip_pkg::coord_type cy);
      pip_pkg::edge_type  e;
      pip_pkg::coord_type lx, ly, hx, hy;
      logic               swap;
      swap = by > cy;
      lx   = swap ? cx : bx;
      ly   = swap ? cy : by;
      hx   = swap ? bx : cx;
      hy   = swap ? by : cy;
      e.d1 = pip_pkg::diff_type'(lx) - pip_pkg::diff_type'(px);
      e.d2 = pip_pkg::diff_type'(hy) - pip_pkg::diff_type'(py);
      e.d3 = pip_pkg::diff_type'(ly) - pip_pkg::diff_type'(py);
      e.d4 = pip_pkg::diff_type'(hx) - pip_pkg::diff_type'(px);
      if (py == by && py == cy) begin
         e.fixed      = 1'b1;
         e.fixed_zero = (bx <= px && px <= cx) || (cx <= px && px <= bx);
      end else if (py == by && px == bx) begin
         e.fixed      = 1'b1;
         e.fixed_zero = 1'b1;
      end else if (py <= ly || py > hy) begin
         e.fixed      = 1'b1;
         e.fixed_zero = 1'b0;
      end else begin
         e.fixed      = 1'b0;
         e.fixed_zero = 1'b0;
      end
      return e;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   assign ax = req_first_vertex ? req_point_x : held_x_ff;
   assign ay = req_first_vertex ? req_point_y : held_y_ff;
   assign sx = req_first_vertex ? req_vertex_x : start_x_ff;
   assign sy = req_first_vertex ? req_vertex_y : start_y_ff;

   always_comb begin
      job.first  = req_first_vertex;
      job.last   = req_last_vertex;
      job.edge_a = edge_prep(ax, ay, prev_x_ff, prev_y_ff, req_vertex_x, req_vertex_y);
      job.edge_b = edge_prep(ax, ay, req_vertex_x, req_vertex_y, sx, sy);
   end

   always_comb begin
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      if (accept) begin
         held_x_in  = ax;
         held_y_in  = ay;
         start_x_in = sx;
         start_y_in = sy;
         prev_x_in  = req_vertex_x;
         prev_y_in  = req_vertex_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff  <= '0;
         held_y_ff  <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else begin
         held_x_ff  <= held_x_in;
         held_y_ff  <= held_y_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
      end
   end

endmodule

// ===== src/pip_queue.sv =====
// Short queue of prepared edge tests between the front end and the back end.
module pip_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pip_pkg::job_type push_job,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output pip_pkg::job_type head_job
);

   pip_pkg::job_type                          slot_ff [pip_pkg::QUEUE_DEPTH];
   logic [pip_pkg::QUEUE_PTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pip_pkg::QUEUE_PTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pip_pkg::QUEUE_CNT_WIDTH-1:0]       count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == pip_pkg::QUEUE_CNT_WIDTH'(pip_pkg::QUEUE_DEPTH);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/pip_back.sv =====
// Back end: forms the cross products, settles each edge factor and keeps the running sign.
module pip_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  pip_pkg::job_type job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_location
);

   pip_pkg::prod_pair_type pa_ff, pa_in, pb_ff, pb_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_first_ff, s1_first_in;
   logic                   s1_last_ff, s1_last_in;
   pip_pkg::sign_type      sign_ff, sign_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             location_ff, location_in;
   pip_pkg::sign_type      fa, fb, s_mid, s_end;
   logic                   rsp_free, s1_consume, s1_load;

   function automatic pip_pkg::prod_pair_type products(input pip_pkg::edge_type e);
      pip_pkg::prod_pair_type r;
      r.fixed      = e.fixed;
      r.fixed_zero = e.fixed_zero;
      r.p          = pip_pkg::prod_type'(e.d1) * pip_pkg::prod_type'(e.d2);
      r.q          = pip_pkg::prod_type'(e.d3) * pip_pkg::prod_type'(e.d4);
      return r;
   endfunction

   function automatic pip_pkg::sign_type factor(input pip_pkg::prod_pair_type r);
      pip_pkg::sign_type f;
      if (r.fixed) begin
         f = r.fixed_zero ? pip_pkg::SIGN_ZERO : pip_pkg::SIGN_PLUS_ONE;
      end else if (r.p > r.q) begin
         f = pip_pkg::SIGN_MINUS_ONE;
      end else if (r.p < r.q) begin
         f = pip_pkg::SIGN_PLUS_ONE;
      end else begin
         f = pip_pkg::SIGN_ZERO;
      end
      return f;
   endfunction

   function automatic pip_pkg::sign_type sign_mul(input pip_pkg::sign_type a,
                                                  input pip_pkg::sign_type b);
      pip_pkg::sign_type s;
      s.zero = a.zero || b.zero;
      s.neg  = !s.zero && (a.neg ^ b.neg);
      return s;
   endfunction

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_consume = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign s1_load    = !s1_valid_ff || s1_consume;
   assign pop        = job_valid && s1_load;

   assign fa    = s1_first_ff ? pip_pkg::SIGN_PLUS_ONE : factor(pa_ff);
   assign fb    = factor(pb_ff);
   assign s_mid = sign_mul(s1_first_ff ? pip_pkg::SIGN_MINUS_ONE : sign_ff, fa);
   assign s_end = s1_last_ff ? sign_mul(s_mid, fb) : s_mid;

   always_comb begin
      s1_valid_in = s1_load ? job_valid : s1_valid_ff;
      s1_first_in = s1_first_ff;
      s1_last_in  = s1_last_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      if (pop) begin
         s1_first_in = job.first;
         s1_last_in  = job.last;
         pa_in       = products(job.edge_a);
         pb_in       = products(job.edge_b);
      end
      sign_in      = s1_consume ? s_end : sign_ff;
      rsp_valid_in = rsp_free ? 1'b0 : rsp_valid_ff;
      location_in  = location_ff;
      if (s1_consume && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         if (s_end.zero) begin
            location_in = pip_pkg::LOC_BOUNDARY;
         end else if (s_end.neg) begin
            location_in = pip_pkg::LOC_OUTSIDE;
         end else begin
            location_in = pip_pkg::LOC_INSIDE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sign_ff      <= pip_pkg::SIGN_MINUS_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      location_ff <= location_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_location = location_ff;

endmodule

// ===== verif/point_in_polygon_location_checker.sv =====
// Checker that predicts the location for each closed polygon and compares it with the block's results.
`timescale 1ns / 1ps

module point_in_polygon_location_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  pip_pkg::coord_type req_point_x,
   input  pip_pkg::coord_type req_point_y,
   input  pip_pkg::coord_type req_vertex_x,
   input  pip_pkg::coord_type req_vertex_y,
   input  logic               req_first_vertex,
   input  logic               req_last_vertex,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_location,
   output int                 error_count,
   output int                 pending_count
);

   typedef logic signed [67:0] wide_type;

   longint     held_x, held_y;
   longint     start_x, start_y;
   longint     last_x, last_y;
   int         chain_sign;
   logic [1:0] expected_locations[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic int edge_crossing_factor(longint ax, longint ay, longint bx, longint by,
                                               longint cx, longint cy);
      longint   tx, ty;
      wide_type d1, d2, d3, d4, p, q;
      if (ay == by && ay == cy) begin
         if ((bx <= ax && ax <= cx) || (cx <= ax && ax <= bx)) return 0;
         return 1;
      end
      if (ay == by && ax == bx) return 0;
      if (by > cy) begin
         tx = bx;
         ty = by;
         bx = cx;
         by = cy;
         cx = tx;
         cy = ty;
      end
      if (ay <= by || ay > cy) return 1;
      d1 = bx - ax;
      d2 = cy - ay;
      d3 = by - ay;
      d4 = cx - ax;
      p  = d1 * d2;
      q  = d3 * d4;
      if (p > q) return -1;
      if (p < q) return 1;
      return 0;
   endfunction

   function automatic logic [1:0] location_of(int sign_value);
      if (sign_value < 0) return pip_pkg::LOC_OUTSIDE;
      if (sign_value == 0) return pip_pkg::LOC_BOUNDARY;
      return pip_pkg::LOC_INSIDE;
   endfunction

   always @(posedge clock) begin : watch
      longint     vx, vy;
      logic [1:0] wanted;
      if (reset) begin
         held_x     = 0;
         held_y     = 0;
         start_x    = 0;
         start_y    = 0;
         last_x     = 0;
         last_y     = 0;
         chain_sign = -1;
         expected_locations.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_locations.size() == 0) begin
               $display("%0t: unexpected location %0d with no request waiting",
                        $time, rsp_location);
               error_count++;
            end else begin
               wanted = expected_locations.pop_front();
               if (rsp_location !== wanted) begin
                  $display("%0t: location mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp_location);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            vx = req_vertex_x;
            vy = req_vertex_y;
            if (req_first_vertex) begin
               held_x     = req_point_x;
               held_y     = req_point_y;
               start_x    = vx;
               start_y    = vy;
               chain_sign = -1;
            end else begin
               chain_sign *= edge_crossing_factor(held_x, held_y, last_x, last_y, vx, vy);
            end
            last_x = vx;
            last_y = vy;
            if (req_last_vertex) begin
               chain_sign *= edge_crossing_factor(held_x, held_y, vx, vy, start_x, start_y);
               expected_locations.push_back(location_of(chain_sign));
            end
         end
      end
      pending_count = expected_locations.size();
   end

endmodule

// ===== verif/point_in_polygon_test_unit_tb.sv =====
// Testbench top for the point-in-polygon test unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module point_in_polygon_test_unit_tb;

   typedef enum int {SPAN_TINY, SPAN_MODEST, SPAN_EXTREME, SPAN_FULL} span_type;

   localparam pip_pkg::coord_type COORD_MAX = 32'h7fff_ffff;
   localparam pip_pkg::coord_type COORD_MIN = 32'h8000_0000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   pip_pkg::coord_type req_point_x;
   pip_pkg::coord_type req_point_y;
   pip_pkg::coord_type req_vertex_x;
   pip_pkg::coord_type req_vertex_y;
   logic               req_first_vertex;
   logic               req_last_vertex;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_location;

   int error_count;
   int pending_count;
   int idle_pct;
   int stall_pct;
   int requests_sent;
   bit hold_off;

   point_in_polygon_test_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_location     (rsp_location)
   );

   point_in_polygon_location_checker location_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_location     (rsp_location),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("point_in_polygon_test_unit_tb: done, errors");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = hold_off || ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic pip_pkg::coord_type pick_coord(span_type span);
      int v;
      case (span)
         SPAN_TINY: begin
            v = $urandom_range(0, 8);
            return v - 4;
         end
         SPAN_MODEST: begin
            v = $urandom_range(0, 2000);
            return v - 1000;
         end
         SPAN_EXTREME: begin
            case ($urandom_range(0, 5))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return 0;
               3: return -1;
               4: return 1;
               default: return COORD_MIN + 1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_vertex(pip_pkg::coord_type px, pip_pkg::coord_type py,
                              pip_pkg::coord_type vx, pip_pkg::coord_type vy,
                              bit first, bit last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_point_x      = px;
      req_point_y      = py;
      req_vertex_x     = vx;
      req_vertex_y     = vy;
      req_first_vertex = first;
      req_last_vertex  = last;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_polygon(span_type span, bit drop_first);
      int                 n;
      pip_pkg::coord_type px, py;
      n  = $urandom_range(1, 8);
      px = pick_coord(span);
      py = pick_coord(span);
      for (int i = 0; i < n; i++) begin
         if (i == 0)
            send_vertex(px, py, pick_coord(span), pick_coord(span), !drop_first, n == 1);
         else
            send_vertex($urandom, $urandom, pick_coord(span), pick_coord(span), 1'b0, i == n - 1);
      end
   endtask

   task automatic send_random_query();
      int       kind;
      int       pick;
      span_type span;
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (pick < 45) span = SPAN_TINY;
      else if (pick < 65) span = SPAN_MODEST;
      else if (pick < 80) span = SPAN_EXTREME;
      else span = SPAN_FULL;
      if (kind < 85)
         send_polygon(span, 1'b0);
      else if (kind < 95)
         send_polygon(span, 1'b1);
      else
         send_vertex($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                     $urandom_range(0, 1));
   endtask

   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      int phase_start;
      idle_by_phase    = '{0, 83, 0, 37};
      stall_by_phase   = '{0, 0, 83, 37};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_point_x      = '0;
      req_point_y      = '0;
      req_vertex_x     = '0;
      req_vertex_y     = '0;
      req_first_vertex = 1'b0;
      req_last_vertex  = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      requests_sent    = 0;
      hold_off         = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A closing vertex straight after reset continues from the cleared state.
      send_vertex(7, -3, 0, 0, 1'b0, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
      send_vertex(0, 0, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 0, COORD_MAX, 1'b0, 1'b1);
      send_vertex(3, 0, 0, 0, 1'b1, 1'b0);
      send_vertex(-1, -1, 10, 0, 1'b0, 1'b0);
      send_vertex(-1, -1, 0, 10, 1'b0, 1'b1);
      // Vertices after a last without a new first carry the reported sign on.
      send_vertex(0, 0, 20, 20, 1'b0, 1'b0);
      send_vertex(0, 0, -20, 5, 1'b0, 1'b1);
      send_vertex(10, 0, 0, 0, 1'b1, 1'b0);
      send_vertex(5, 5, 10, 0, 1'b0, 1'b0);
      send_vertex(5, 5, 0, 10, 1'b0, 1'b1);

      for (int p = 0; p < 4; p++) begin
         idle_pct    = idle_by_phase[p];
         stall_pct   = stall_by_phase[p];
         phase_start = requests_sent;
         if (p == 0) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (80) @(negedge clock);
                  hold_off = 1'b0;
               end
               repeat (6) send_polygon(SPAN_TINY, 1'b0);
            join
         end
         while (requests_sent - phase_start < 100) send_random_query();
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("point_in_polygon_test_unit_tb: done, clean");
      else
         $display("point_in_polygon_test_unit_tb: done, errors");
      $finish;
   end

endmodule
